// ===== hw/rtl/ddlfe_pkg.sv =====
// ----------------------------------------------------------------------------
// ddlfe_pkg: shared types and constants of the depth-driven LED fade engine
// Item formats, configuration register codes and reset values, the lifespan
// generator constants and the output buffer size.
// ----------------------------------------------------------------------------
package ddlfe_pkg;

    localparam int IDX_W   = 14;
    localparam int DEPTH_W = 16;
    localparam int LEVEL_W = 8;

    localparam int NUM_LEDS_DEF = 16384;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_NEAR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FAR   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = CFG_IDX_W'(3);

    localparam logic [DEPTH_W-1:0] RANGE_NEAR_RST  = 16'd500;
    localparam logic [DEPTH_W-1:0] RANGE_FAR_RST   = 16'd1000;
    localparam logic [LEVEL_W-1:0] IDLE_LEVEL_RST  = 8'd63;
    localparam logic [15:0]        RANDOM_SEED_RST = 16'd44257;

    // Galois LFSR, shift right
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // lifespan draws: low bound and span count (hi - lo + 1)
    localparam logic [7:0] SPAN_OUT_LO  = 8'd120;
    localparam logic [7:0] SPAN_OUT_CNT = 8'd121;
    localparam logic [7:0] SPAN_IN_LO   = 8'd60;
    localparam logic [7:0] SPAN_IN_CNT  = 8'd121;
    localparam logic [7:0] SPAN_OFF_LO  = 8'd30;
    localparam logic [7:0] SPAN_OFF_CNT = 8'd61;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

    // result buffer; must exceed the pipeline latency for full rate
    localparam int OUT_DEPTH = 16;

    typedef struct packed {
        logic [IDX_W-1:0]   led_index;
        logic               in_window;
        logic [DEPTH_W-1:0] depth_sample;
    } sample_t;

    typedef struct packed {
        logic [IDX_W-1:0]   led_out_index;
        logic [LEVEL_W-1:0] brightness;
        logic               led_active;
    } result_t;

endpackage

// ===== hw/rtl/depth_driven_led_fade_engine_unit.sv =====
// ----------------------------------------------------------------------------
// depth_driven_led_fade_engine_unit: per-LED fade state machine over memory
// Reads LED state from a simple dual-port synchronous memory, updates it in
// a combinational stage, writes it back, then derives the brightness through a
// pipelined divider.
// ----------------------------------------------------------------------------
// Takes one item per clock while sample_stall is low and returns one result per
// item, in order. The rate is set by the read-modify-write of the per-LED state
// memory (one read and one write each cycle, back-to-back hits on one LED are
// forwarded) and by the lifespan LFSR, which steps at most once per item.
// Brightness comes out of an 8-stage restoring divider. Up to 16 items may be
// outstanding; results wait in a 16-entry buffer, and outside the clearing pass
// sample_stall rises only when that budget is used up. After reset the block
// clears its state memory, one LED per cycle, over all NUM_LEDS entries;
// sample_stall is high during that pass, while configuration writes are taken
// at all times (cfg_ready is tied high).
module depth_driven_led_fade_engine_unit #(
    parameter int NUM_LEDS = ddlfe_pkg::NUM_LEDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  ddlfe_pkg::sample_t               sample,
    output logic                             led_valid,
    input  logic                             led_stall,
    output ddlfe_pkg::result_t               led,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ddlfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddlfe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ddlfe_pkg::*;

    localparam int AW  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int XW  = (AW > IDX_W) ? AW : IDX_W;
    localparam int OPW = $clog2(OUT_DEPTH);
    localparam int CW  = $clog2(OUT_DEPTH + 1);
    localparam logic [16:0]   LED_COUNT = 17'(NUM_LEDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_LEDS - 1);
    localparam int DIV_STEPS = LEVEL_W;

    typedef struct packed {
        logic       act;
        logic [7:0] age;
        logic [7:0] span;
    } led_state_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               act;
        logic               use_div;
        logic [LEVEL_W-1:0] level;
    } pipe_t;

    // configuration and generator
    logic [DEPTH_W-1:0] near_reg;
    logic [DEPTH_W-1:0] far_reg;
    logic [LEVEL_W-1:0] idle_reg;
    logic [15:0]        lfsr_reg;
    logic               cfg_we;

    // clearing pass
    logic               clr_reg;
    logic [AW-1:0]      clr_addr_reg;

    // state memory
    led_state_t         mem [0:NUM_LEDS-1];
    led_state_t         rd_reg;
    logic               fwd_hit_reg;
    led_state_t         fwd_data_reg;
    logic [XW-1:0]      in_idx_x;
    logic [XW-1:0]      s1_idx_x;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;

    logic               accept;

    // update stage
    logic               v1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic               win1_reg;
    logic [DEPTH_W-1:0] d1_reg;

    led_state_t         st_s1;
    led_state_t         wdata_s1;
    logic               idx_ok_s1;
    logic               in_range_s1;
    logic               we_s1;
    logic               draw_s1;
    logic [15:0]        lfsr_seed_s1;
    logic [15:0]        lfsr_next;
    logic [7:0]         draw_lo_s1;
    logic [7:0]         draw_cnt_s1;
    logic [23:0]        draw_prod_s1;
    logic [7:0]         draw_val_s1;
    logic [7:0]         age_dec_s1;
    logic [DEPTH_W-1:0] m_s1;
    logic [DEPTH_W-1:0] n_s1;
    pipe_t              pipe_s1;

    // multiply stages
    logic               v2_reg;
    pipe_t              pipe2_reg;
    logic [7:0]         age2_reg;
    logic [7:0]         span2_reg;
    logic [DEPTH_W-1:0] m2_reg;
    logic [DEPTH_W-1:0] n2_reg;

    logic               v3_reg;
    pipe_t              pipe3_reg;
    logic [23:0]        a3_reg;
    logic [23:0]        b3_reg;

    // divider stages
    logic               vd_reg   [0:DIV_STEPS];
    pipe_t              pd_reg   [0:DIV_STEPS];
    logic [31:0]        rem_reg  [0:DIV_STEPS];
    logic [23:0]        den_reg  [0:DIV_STEPS];
    logic [7:0]         q_reg    [0:DIV_STEPS];
    logic [32:0]        dsh      [0:DIV_STEPS-1];
    logic [31:0]        rem_next [0:DIV_STEPS-1];
    logic [7:0]         q_next   [0:DIV_STEPS-1];

    // result buffer
    result_t            fifo_mem [0:OUT_DEPTH-1];
    logic [OPW-1:0]     wr_ptr_reg;
    logic [OPW-1:0]     rd_ptr_reg;
    logic [CW-1:0]      fifo_cnt_reg;
    logic [CW-1:0]      credit_reg;
    logic               out_acc;
    result_t            fin;

    assign cfg_ready    = 1'b1;
    assign cfg_we       = cfg_valid && cfg_ready;
    assign sample_stall = clr_reg || (credit_reg == CW'(OUT_DEPTH));
    assign accept       = sample_valid && !sample_stall;

    assign in_idx_x = XW'(sample.led_index);
    assign s1_idx_x = XW'(idx1_reg);
    assign rd_addr  = in_idx_x[AW-1:0];
    assign wr_addr  = s1_idx_x[AW-1:0];

    // ------------------------------------------------------------------------
    // configuration registers and lifespan generator
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= RANGE_NEAR_RST;
            far_reg  <= RANGE_FAR_RST;
            idle_reg <= IDLE_LEVEL_RST;
            lfsr_reg <= RANDOM_SEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RANGE_NEAR:  near_reg <= cfg_data;
                CFG_RANGE_FAR:   far_reg  <= cfg_data;
                CFG_IDLE_LEVEL:  idle_reg <= cfg_data[LEVEL_W-1:0];
                CFG_RANDOM_SEED: lfsr_reg <= cfg_data;
                default:         ;
            endcase
        end
        else if (draw_s1)
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    // ------------------------------------------------------------------------
    // clearing pass after reset
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // state memory: reads on accept, writes from clearing pass or update stage
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (we_s1)
        begin
            mem[wr_addr] <= wdata_s1;
        end
        if (accept)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // update stage
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx1_reg     <= sample.led_index;
            win1_reg     <= sample.in_window;
            d1_reg       <= sample.depth_sample;
            // the write of the item ahead lands on this same edge
            fwd_hit_reg  <= we_s1 && (idx1_reg == sample.led_index);
            fwd_data_reg <= wdata_s1;
        end
    end

    assign st_s1       = fwd_hit_reg ? fwd_data_reg : rd_reg;
    assign idx_ok_s1   = {3'b000, idx1_reg} < LED_COUNT;
    assign in_range_s1 = (d1_reg >= near_reg) && (d1_reg <= far_reg);
    assign age_dec_s1  = st_s1.age - 8'd1;

    assign lfsr_seed_s1 = (lfsr_reg == 16'd0) ? 16'd1 : lfsr_reg;
    assign lfsr_next    = {1'b0, lfsr_seed_s1[15:1]} ^ (lfsr_seed_s1[0] ? LFSR_MASK : 16'd0);

    always_comb
    begin
        if (!win1_reg)
        begin
            draw_lo_s1  = SPAN_OUT_LO;
            draw_cnt_s1 = SPAN_OUT_CNT;
        end
        else if (in_range_s1)
        begin
            draw_lo_s1  = SPAN_IN_LO;
            draw_cnt_s1 = SPAN_IN_CNT;
        end
        else
        begin
            draw_lo_s1  = SPAN_OFF_LO;
            draw_cnt_s1 = SPAN_OFF_CNT;
        end
    end

    assign draw_prod_s1 = 24'(lfsr_next) * 24'(draw_cnt_s1);
    assign draw_val_s1  = draw_lo_s1 + draw_prod_s1[23:16];

    always_comb
    begin
        wdata_s1        = st_s1;
        draw_s1         = 1'b0;
        m_s1            = 16'd1;
        n_s1            = 16'd1;
        pipe_s1.idx     = idx1_reg;
        pipe_s1.act     = st_s1.act;
        pipe_s1.use_div = 1'b0;
        pipe_s1.level   = '0;

        if (!win1_reg)
        begin
            if (st_s1.age != 8'd0)
            begin
                wdata_s1.age    = age_dec_s1;
                pipe_s1.use_div = 1'b1;
            end
            else
            begin
                draw_s1        = 1'b1;
                wdata_s1.span  = draw_val_s1;
                wdata_s1.age   = draw_val_s1;
                pipe_s1.level  = FULL_LEVEL;
            end
        end
        else if (in_range_s1)
        begin
            wdata_s1.act = 1'b1;
            if (st_s1.age != 8'd0)
            begin
                wdata_s1.age    = age_dec_s1;
                pipe_s1.use_div = 1'b1;
                if (far_reg != near_reg)
                begin
                    m_s1 = far_reg - d1_reg;
                    n_s1 = far_reg - near_reg;
                end
            end
            else
            begin
                wdata_s1.act  = 1'b0;
                draw_s1       = 1'b1;
                wdata_s1.span = draw_val_s1;
                wdata_s1.age  = draw_val_s1;
            end
        end
        else if (!st_s1.act)
        begin
            pipe_s1.level = idle_reg;
        end
        else if (st_s1.age != 8'd0)
        begin
            wdata_s1.age    = age_dec_s1;
            pipe_s1.use_div = 1'b1;
        end
        else
        begin
            wdata_s1.act  = 1'b0;
            draw_s1       = 1'b1;
            wdata_s1.span = draw_val_s1;
            wdata_s1.age  = draw_val_s1;
        end

        // zero lifespan fades to black
        if (st_s1.span == 8'd0)
        begin
            pipe_s1.use_div = 1'b0;
        end

        pipe_s1.act = wdata_s1.act;

        // LED outside the array: black, inactive, nothing touched
        if (!idx_ok_s1)
        begin
            draw_s1         = 1'b0;
            pipe_s1.act     = 1'b0;
            pipe_s1.use_div = 1'b0;
            pipe_s1.level   = '0;
        end

        draw_s1 = draw_s1 && v1_reg;
    end

    assign we_s1 = v1_reg && idx_ok_s1;

    // ------------------------------------------------------------------------
    // numerator and denominator products
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe2_reg <= pipe_s1;
        age2_reg  <= wdata_s1.age;
        span2_reg <= st_s1.span;
        m2_reg    <= m_s1;
        n2_reg    <= n_s1;

        pipe3_reg <= pipe2_reg;
        a3_reg    <= 24'(age2_reg) * 24'(m2_reg);
        b3_reg    <= 24'(span2_reg) * 24'(n2_reg);
    end

    // ------------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            dsh[j] = 33'(den_reg[j]) << (DIV_STEPS - 1 - j);
            if ({1'b0, rem_reg[j]} >= dsh[j])
            begin
                rem_next[j] = rem_reg[j] - dsh[j][31:0];
                q_next[j]   = q_reg[j] | (8'd1 << (DIV_STEPS - 1 - j));
            end
            else
            begin
                rem_next[j] = rem_reg[j];
                q_next[j]   = q_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                vd_reg[j] <= 1'b0;
            end
        end
        else
        begin
            vd_reg[0] <= v3_reg;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                vd_reg[j+1] <= vd_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pd_reg[0]  <= pipe3_reg;
        // age * m * 255
        rem_reg[0] <= 32'({a3_reg, 8'd0}) - 32'(a3_reg);
        den_reg[0] <= b3_reg;
        q_reg[0]   <= '0;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            pd_reg[j+1]  <= pd_reg[j];
            rem_reg[j+1] <= rem_next[j];
            den_reg[j+1] <= den_reg[j];
            q_reg[j+1]   <= q_next[j];
        end
    end

    // ------------------------------------------------------------------------
    // result buffer and outstanding-item budget
    // ------------------------------------------------------------------------
    assign fin.led_out_index = pd_reg[DIV_STEPS].idx;
    assign fin.brightness    = pd_reg[DIV_STEPS].use_div ? q_reg[DIV_STEPS]
                                                         : pd_reg[DIV_STEPS].level;
    assign fin.led_active    = pd_reg[DIV_STEPS].act;

    assign led_valid = fifo_cnt_reg != '0;
    assign led       = fifo_mem[rd_ptr_reg];
    assign out_acc   = led_valid && !led_stall;

    always_ff @(posedge clk)
    begin
        if (vd_reg[DIV_STEPS])
        begin
            fifo_mem[wr_ptr_reg] <= fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            if (vd_reg[DIV_STEPS])
            begin
                wr_ptr_reg <= wr_ptr_reg + OPW'(1);
            end
            if (out_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + OPW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + CW'(vd_reg[DIV_STEPS]) - CW'(out_acc);
            credit_reg   <= credit_reg + CW'(accept) - CW'(out_acc);
        end
    end

endmodule
